### src/xpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpr_pkg
// shared constants, codes and word types of the xor parity recovery block
// ----------------------------------------------------------------------------
package xpr_pkg;

   localparam int RING_SLOTS       = 16;
   localparam int SLOT_BYTES       = 2048;
   localparam int MAX_RESULT_BYTES = 2048;
   localparam int MAX_GROUP        = 8;
   localparam int HEADER_BYTES     = 4;
   localparam int MIN_GROUP        = 2;

   localparam int POS_LIMIT = (SLOT_BYTES > MAX_RESULT_BYTES + HEADER_BYTES) ?
                              SLOT_BYTES : MAX_RESULT_BYTES + HEADER_BYTES;
   localparam int POS_W       = $clog2(POS_LIMIT + 2);
   localparam int SLOT_W      = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
   localparam int SLOT_ADDR_W = $clog2(RING_SLOTS * SLOT_BYTES);
   localparam int WORK_ADDR_W = $clog2(MAX_RESULT_BYTES);

   // request queue, depth a power of two
   localparam int REQ_DEPTH = 4;
   localparam int REQ_PTR_W = $clog2(REQ_DEPTH);
   localparam int REQ_CNT_W = $clog2(REQ_DEPTH + 1);

   localparam logic [1:0] OP_DATA   = 2'd0;
   localparam logic [1:0] OP_PARITY = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [2:0] ST_RECOVERED = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_BAD_COUNT = 3'd2;
   localparam logic [2:0] ST_NONE_MISS = 3'd3;
   localparam logic [2:0] ST_MULTI     = 3'd4;

   localparam logic KIND_VERDICT = 1'b0;
   localparam logic KIND_READ    = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] seq;
      logic [7:0]  flags;
      logic [7:0]  stream;
      logic [7:0]  data;
      logic        last;
      logic [10:0] ridx;
   } item_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  status;
      logic [15:0] seq;
      logic [7:0]  flags;
      logic [7:0]  stream;
      logic [11:0] length;
      logic [7:0]  rbyte;
      logic [31:0] recovered;
      logic [31:0] lost;
   } rsp_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } item_link_type;

endpackage

### src/xpr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpr_front
// accepts request words, decodes the command and queues all but the unused one for the engine
// ----------------------------------------------------------------------------
module xpr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  xpr_pkg::item_type      req_item,
   output xpr_pkg::item_link_type head,
   input  logic                   take
);

   localparam int PTW = xpr_pkg::REQ_PTR_W;
   localparam int CW  = xpr_pkg::REQ_CNT_W;

   xpr_pkg::item_type q_ff [xpr_pkg::REQ_DEPTH];
   logic [PTW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           do_push, do_pop, keep;

   assign full    = (cnt_ff == CW'(xpr_pkg::REQ_DEPTH));
   assign do_push = push && !full;
   // unused command is dropped here
   assign keep    = (req_item.op != xpr_pkg::OP_NONE);
   assign do_pop  = take && (cnt_ff != '0);

   assign head.valid = (cnt_ff != '0);
   assign head.item  = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_push && keep) begin
         wp_in = wp_ff + PTW'(1);
      end
      if (do_pop) begin
         rp_in = rp_ff + PTW'(1);
      end
      cnt_in = cnt_ff + CW'(do_push && keep) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push && keep) begin
         q_ff[wp_ff] <= req_item;
      end
   end

endmodule

### src/xpr_rsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpr_rsp_queue
// two-entry result queue between the engine and the response side
// ----------------------------------------------------------------------------
module xpr_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr,
   input  xpr_pkg::rsp_type  wr_word,
   output logic              room,
   output logic              empty,
   input  logic              pop,
   output xpr_pkg::rsp_type  rd_word
);

   xpr_pkg::rsp_type q_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_pop;

   assign empty   = (cnt_ff == 2'd0);
   assign room    = (cnt_ff != 2'd2);
   assign do_pop  = pop && !empty;
   assign rd_word = q_ff[rp_ff];
   assign cnt_in  = cnt_ff + 2'(wr) - 2'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_ff ^ wr;
         rp_ff  <= rp_ff ^ do_pop;
         cnt_ff <= cnt_in;
      end
      if (wr) begin
         q_ff[wp_ff] <= wr_word;
      end
   end

endmodule

### src/xpr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpr_back
// slot ring, parity header, group scan and xor rebuild engine
// ----------------------------------------------------------------------------
module xpr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  xpr_pkg::item_link_type head,
   output logic                   take,
   input  logic                   rsp_room,
   output logic                   rsp_wr,
   output xpr_pkg::rsp_type       rsp_word
);

   localparam int PW = xpr_pkg::POS_W;
   localparam int SW = xpr_pkg::SLOT_W;
   localparam int AW = xpr_pkg::SLOT_ADDR_W;
   localparam int WW = xpr_pkg::WORK_ADDR_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_EVAL  = 4'd3;
   localparam logic [3:0] S_SEL   = 4'd4;
   localparam logic [3:0] S_XOR   = 4'd5;
   localparam logic [3:0] S_DRAIN = 4'd6;
   localparam logic [3:0] S_DONE  = 4'd7;
   localparam logic [3:0] S_READ  = 4'd8;

   // memories
   logic [7:0] slot_mem_ff [xpr_pkg::RING_SLOTS * xpr_pkg::SLOT_BYTES];
   logic [7:0] work_mem_ff [xpr_pkg::MAX_RESULT_BYTES];
   logic          s_we, w_we;
   logic [AW-1:0] s_waddr, s_raddr;
   logic [WW-1:0] w_waddr, w_raddr;
   logic [7:0]    s_wdata, w_wdata, s_rd_ff, w_rd_ff;

   // slot metadata
   logic [PW-1:0] slen_ff  [xpr_pkg::RING_SLOTS];
   logic [7:0]    sflag_ff [xpr_pkg::RING_SLOTS];
   logic [15:0]   sseq_ff  [xpr_pkg::RING_SLOTS];
   logic [xpr_pkg::RING_SLOTS-1:0] svalid_ff;
   logic          meta_we;
   logic [SW-1:0] meta_slot;

   logic [3:0]    state_ff, state_in;
   logic [PW-1:0] pos_ff, pos_in, total_ff, total_in;
   logic [31:0]   hdr_ff, hdr_in;
   logic [PW-1:0] wlen_ff, wlen_in;
   logic [31:0]   rec_ff, rec_in, lost_ff, lost_in;
   logic [7:0]    stream_ff, stream_in;
   logic [7:0]    i_ff, i_in, miss_ff, miss_in;
   logic [1:0]    missing_ff, missing_in;
   logic [PW-1:0] rlen_ff, rlen_in, alen_ff, alen_in, mlen_ff, mlen_in;
   logic [PW-1:0] xl_ff, xl_in, j_ff, j_in;
   logic [SW-1:0] ms_ff, ms_in;
   logic [7:0]    rflags_ff, rflags_in;
   logic          rok_ff, rok_in;
   logic          vd_ff, vd_in, aok_ff, aok_in, bok_ff, bok_in;
   logic [WW-1:0] jd_ff, jd_in;

   xpr_pkg::item_type it;
   logic [15:0]   seq_i;
   logic [SW-1:0] s_i, s_it;
   logic [7:0]    count;
   logic [PW-1:0] mx, hb_len;
   logic [PW-1:0] p_hdr;

   assign it    = head.item;
   assign count = hdr_ff[15:8];
   assign seq_i = hdr_ff[31:16] + 16'(i_ff);
   assign s_i   = SW'(seq_i % 16'(xpr_pkg::RING_SLOTS));
   assign s_it  = SW'(it.seq % 16'(xpr_pkg::RING_SLOTS));
   assign p_hdr = pos_ff - PW'(xpr_pkg::HEADER_BYTES);

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      total_in   = total_ff;
      hdr_in     = hdr_ff;
      wlen_in    = wlen_ff;
      rec_in     = rec_ff;
      lost_in    = lost_ff;
      stream_in  = stream_ff;
      i_in       = i_ff;
      miss_in    = miss_ff;
      missing_in = missing_ff;
      rlen_in    = rlen_ff;
      alen_in    = alen_ff;
      mlen_in    = mlen_ff;
      xl_in      = xl_ff;
      j_in       = j_ff;
      ms_in      = ms_ff;
      rflags_in  = rflags_ff;
      rok_in     = rok_ff;
      vd_in      = 1'b0;
      jd_in      = WW'(j_ff);
      aok_in     = (j_ff < alen_ff);
      bok_in     = (j_ff < mlen_ff);
      take       = 1'b0;
      s_we       = 1'b0;
      s_waddr    = AW'(s_it * xpr_pkg::SLOT_BYTES + 32'(pos_ff));
      s_wdata    = it.data;
      s_raddr    = AW'(ms_ff * xpr_pkg::SLOT_BYTES + 32'(j_ff));
      w_we       = 1'b0;
      w_waddr    = WW'(p_hdr);
      w_wdata    = it.data;
      w_raddr    = WW'(j_ff);
      meta_we    = 1'b0;
      meta_slot  = s_it;
      rsp_wr     = 1'b0;
      rsp_word   = '0;
      rsp_word.kind      = xpr_pkg::KIND_VERDICT;
      rsp_word.recovered = rec_ff;
      rsp_word.lost      = lost_ff;
      mx     = '0;
      hb_len = '0;

      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               case (it.op)
                  xpr_pkg::OP_DATA: begin
                     take = 1'b1;
                     s_we = (pos_ff < PW'(xpr_pkg::SLOT_BYTES));
                     if (it.last) begin
                        meta_we = 1'b1;
                        pos_in  = '0;
                     end else if (pos_ff < PW'(xpr_pkg::POS_LIMIT)) begin
                        pos_in = pos_ff + 1'b1;
                     end
                  end
                  xpr_pkg::OP_PARITY: begin
                     if (!it.last || rsp_room) begin
                        take = 1'b1;
                        if (pos_ff == '0) begin
                           wlen_in = '0;
                        end
                        case (pos_ff)
                           PW'(0): hdr_in[31:24] = it.data;
                           PW'(1): hdr_in[23:16] = it.data;
                           PW'(2): hdr_in[15:8]  = it.data;
                           PW'(3): hdr_in[7:0]   = it.data;
                           default: hdr_in = hdr_ff;
                        endcase
                        w_we = (pos_ff >= PW'(xpr_pkg::HEADER_BYTES)) &&
                               (p_hdr < PW'(xpr_pkg::MAX_RESULT_BYTES));
                        if (it.last) begin
                           total_in  = pos_ff + 1'b1;
                           stream_in = it.stream;
                           pos_in    = '0;
                           state_in  = S_CHECK;
                        end else if (pos_ff < PW'(xpr_pkg::POS_LIMIT)) begin
                           pos_in = pos_ff + 1'b1;
                        end
                     end
                  end
                  xpr_pkg::OP_READ: begin
                     if (rsp_room) begin
                        take     = 1'b1;
                        w_raddr  = WW'(it.ridx);
                        rok_in   = (PW'(it.ridx) < wlen_ff) &&
                                   (32'(it.ridx) < xpr_pkg::MAX_RESULT_BYTES);
                        state_in = S_READ;
                     end
                  end
                  default: take = 1'b1;
               endcase
            end
         end
         S_READ: begin
            rsp_wr         = 1'b1;
            rsp_word.kind  = xpr_pkg::KIND_READ;
            rsp_word.rbyte = rok_ff ? w_rd_ff : 8'd0;
            state_in       = S_IDLE;
         end
         S_CHECK: begin
            if (total_ff < PW'(xpr_pkg::HEADER_BYTES)) begin
               rsp_wr          = 1'b1;
               rsp_word.status = xpr_pkg::ST_SHORT;
               state_in        = S_IDLE;
            end else if (count < 8'(xpr_pkg::MIN_GROUP) ||
                         count > 8'(xpr_pkg::MAX_GROUP)) begin
               rsp_wr          = 1'b1;
               rsp_word.status = xpr_pkg::ST_BAD_COUNT;
               state_in        = S_IDLE;
            end else begin
               i_in       = '0;
               missing_in = '0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!(svalid_ff[s_i] && sseq_ff[s_i] == seq_i)) begin
               missing_in = (missing_ff == 2'd2) ? 2'd2 : missing_ff + 2'd1;
               miss_in    = i_ff;
            end
            i_in = i_ff + 8'd1;
            if (i_ff == count - 8'd1) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (missing_ff == 2'd0) begin
               rsp_wr          = 1'b1;
               rsp_word.status = xpr_pkg::ST_NONE_MISS;
               state_in        = S_IDLE;
            end else if (missing_ff != 2'd1) begin
               lost_in         = lost_ff + 32'd1;
               rsp_wr          = 1'b1;
               rsp_word.status = xpr_pkg::ST_MULTI;
               rsp_word.lost   = lost_ff + 32'd1;
               state_in        = S_IDLE;
            end else begin
               hb_len    = total_ff - PW'(xpr_pkg::HEADER_BYTES);
               rlen_in   = (hb_len > PW'(xpr_pkg::MAX_RESULT_BYTES)) ?
                           PW'(xpr_pkg::MAX_RESULT_BYTES) : hb_len;
               rflags_in = hdr_ff[7:0];
               i_in      = '0;
               state_in  = S_SEL;
            end
         end
         S_SEL: begin
            if (i_ff == count) begin
               state_in = S_DONE;
            end else begin
               i_in = i_ff + 8'd1;
               if (i_ff != miss_ff) begin
                  mx        = (slen_ff[s_i] > rlen_ff) ? slen_ff[s_i] : rlen_ff;
                  xl_in     = (mx > PW'(xpr_pkg::MAX_RESULT_BYTES)) ?
                              PW'(xpr_pkg::MAX_RESULT_BYTES) : mx;
                  ms_in     = s_i;
                  mlen_in   = slen_ff[s_i];
                  alen_in   = rlen_ff;
                  rlen_in   = xl_in;
                  rflags_in = rflags_ff ^ sflag_ff[s_i];
                  j_in      = '0;
                  if (xl_in != '0) begin
                     state_in = S_XOR;
                  end
               end
            end
         end
         S_XOR: begin
            vd_in = 1'b1;
            j_in  = j_ff + 1'b1;
            if (j_ff == xl_ff - 1'b1) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_SEL;
         end
         S_DONE: begin
            wlen_in            = rlen_ff;
            rec_in             = rec_ff + 32'd1;
            rsp_wr             = 1'b1;
            rsp_word.status    = xpr_pkg::ST_RECOVERED;
            rsp_word.seq       = hdr_ff[31:16] + 16'(miss_ff);
            rsp_word.flags     = rflags_ff;
            rsp_word.stream    = stream_ff;
            rsp_word.length    = 12'(rlen_ff);
            rsp_word.recovered = rec_ff + 32'd1;
            state_in           = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // xor write-back, in the cycle after the reads
      if (vd_ff) begin
         w_we    = 1'b1;
         w_waddr = jd_ff;
         w_wdata = (aok_ff ? w_rd_ff : 8'd0) ^ (bok_ff ? s_rd_ff : 8'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pos_ff     <= '0;
         hdr_ff     <= '0;
         wlen_ff    <= '0;
         rec_ff     <= '0;
         lost_ff    <= '0;
         svalid_ff  <= '0;
         vd_ff      <= 1'b0;
         for (int k = 0; k < xpr_pkg::RING_SLOTS; k++) begin
            slen_ff[k]  <= '0;
            sflag_ff[k] <= '0;
            sseq_ff[k]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         hdr_ff   <= hdr_in;
         wlen_ff  <= wlen_in;
         rec_ff   <= rec_in;
         lost_ff  <= lost_in;
         vd_ff    <= vd_in;
         if (meta_we) begin
            slen_ff[meta_slot]   <= (pos_ff >= PW'(xpr_pkg::SLOT_BYTES)) ?
                                    PW'(xpr_pkg::SLOT_BYTES) : pos_ff + 1'b1;
            sflag_ff[meta_slot]  <= it.flags;
            sseq_ff[meta_slot]   <= it.seq;
            svalid_ff[meta_slot] <= 1'b1;
         end
      end
      total_ff   <= total_in;
      stream_ff  <= stream_in;
      i_ff       <= i_in;
      miss_ff    <= miss_in;
      missing_ff <= missing_in;
      rlen_ff    <= rlen_in;
      alen_ff    <= alen_in;
      mlen_ff    <= mlen_in;
      xl_ff      <= xl_in;
      j_ff       <= j_in;
      ms_ff      <= ms_in;
      rflags_ff  <= rflags_in;
      rok_ff     <= rok_in;
      jd_ff      <= jd_in;
      aok_ff     <= aok_in;
      bok_ff     <= bok_in;
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         slot_mem_ff[s_waddr] <= s_wdata;
      end
      s_rd_ff <= slot_mem_ff[s_raddr];
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         work_mem_ff[w_waddr] <= w_wdata;
      end
      w_rd_ff <= work_mem_ff[w_raddr];
   end

endmodule

### src/xor_parity_packet_recovery_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_parity_packet_recovery_top
// stores data packets in a slot ring and rebuilds one lost group member
// from a parity packet by xor
// ----------------------------------------------------------------------------
//  channel   ports            handshake
//  request   push/full req_*  word taken when push and not full
//  response  empty/pop rsp_*  word taken when pop and not empty
//
//  data bytes and parity bytes not ending a parity packet are taken without waiting for response room
//  a read goes through the registered work memory read before its response is written
//  a parity last byte starts a header check; a header fault ends there, else
//  the group is scanned for a verdict, and a rebuild runs an xor pass per present member
//  reset clears slot valid marks, counters and queues
//  a four-word request queue lets push continue while the engine is busy
// ----------------------------------------------------------------------------
module xor_parity_packet_recovery_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_pkt_seq,
   input  logic [7:0]  req_pkt_flags,
   input  logic [7:0]  req_stream_tag,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [10:0] req_read_index,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_rec_seq,
   output logic [7:0]  rsp_rec_flags,
   output logic [7:0]  rsp_rec_stream,
   output logic [11:0] rsp_rec_length,
   output logic [7:0]  rsp_read_byte,
   output logic [31:0] rsp_recovered_total,
   output logic [31:0] rsp_unrecoverable_total
);

   xpr_pkg::item_type      req_item;
   xpr_pkg::item_link_type head;
   xpr_pkg::rsp_type       wr_word, rd_word;
   logic take, room, wr;

   assign req_item.op     = req_cmd;
   assign req_item.seq    = req_pkt_seq;
   assign req_item.flags  = req_pkt_flags;
   assign req_item.stream = req_stream_tag;
   assign req_item.data   = req_data_byte;
   assign req_item.last   = req_last_byte;
   assign req_item.ridx   = req_read_index;

   xpr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .head     (head),
      .take     (take)
   );

   xpr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .take     (take),
      .rsp_room (room),
      .rsp_wr   (wr),
      .rsp_word (wr_word)
   );

   xpr_rsp_queue u_rsp (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .wr_word (wr_word),
      .room    (room),
      .empty   (empty),
      .pop     (pop),
      .rd_word (rd_word)
   );

   assign rsp_kind                = rd_word.kind;
   assign rsp_status              = rd_word.status;
   assign rsp_rec_seq             = rd_word.seq;
   assign rsp_rec_flags           = rd_word.flags;
   assign rsp_rec_stream          = rd_word.stream;
   assign rsp_rec_length          = rd_word.length;
   assign rsp_read_byte           = rd_word.rbyte;
   assign rsp_recovered_total     = rd_word.recovered;
   assign rsp_unrecoverable_total = rd_word.lost;

endmodule
